[hw/rtl/tbtf_pkg.sv]
// Package for the thermistor beta temperature filter.
// Holds widths, reset values, status codes and the front-to-back record type.
// No dependencies.
`default_nettype none
package tbtf_pkg;

    localparam int WINDOW_DEPTH_DEF   = 64;
    localparam int ADC_FULL_SCALE_DEF = 1023;

    localparam int SAMPLE_W = 10;
    localparam int TEMP_W   = 16;
    localparam int LAST_W   = 18;

    // Register indexes
    localparam logic [2:0] REG_SUPPLY  = 3'd0;
    localparam logic [2:0] REG_RFIX    = 3'd1;
    localparam logic [2:0] REG_RNOM    = 3'd2;
    localparam logic [2:0] REG_BETA    = 3'd3;
    localparam logic [2:0] REG_T0      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VOLT  = 2'd1;
    localparam logic [1:0] ST_RES   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic signed [LAST_W-1:0] LAST_RESET = -18'sd99900;

    // Front to back record: window sum and span after the sample is added
    typedef struct packed {
        logic [31:0] sum;
        logic [31:0] span;
    } avg_rec_t;

endpackage
`default_nettype wire

[hw/rtl/tbtf_front.sv]
// Front part: sample window memory, running sum, fill tracking.
// Depends on tbtf_pkg.
`default_nettype none
module tbtf_front #(
    parameter int WINDOW_DEPTH   = tbtf_pkg::WINDOW_DEPTH_DEF,
    parameter int ADC_FULL_SCALE = tbtf_pkg::ADC_FULL_SCALE_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [tbtf_pkg::SAMPLE_W-1:0]   sample,
    output logic                           rec_valid,
    input  wire                            rec_ready,
    output tbtf_pkg::avg_rec_t             rec
);
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_OUT  = 3'b100
    } fstate_t;

    logic [tbtf_pkg::SAMPLE_W-1:0] mem [WINDOW_DEPTH];
    logic [tbtf_pkg::SAMPLE_W-1:0] old_reg;
    fstate_t state_reg, state_next;
    logic [AW-1:0] slot_reg;
    logic full_reg;
    logic [31:0] sum_reg;
    logic [CW-1:0] cnt_reg;
    logic [tbtf_pkg::SAMPLE_W-1:0] smp_reg;
    tbtf_pkg::avg_rec_t rec_reg;

    assign in_ready  = (state_reg == F_IDLE);
    assign rec_valid = (state_reg == F_OUT);
    assign rec       = rec_reg;

    // Window memory: read old entry then overwrite
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            old_reg <= mem[slot_reg];
            mem[slot_reg] <= sample;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_READ;
            F_READ: state_next = F_OUT;
            F_OUT:  if (rec_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            slot_reg  <= '0;
            full_reg  <= 1'b0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_READ)
            begin
                sum_reg <= sum_reg - (full_reg ? 32'(old_reg) : 32'd0) + 32'(smp_reg);
                if (32'(slot_reg) == WINDOW_DEPTH - 1)
                begin
                    slot_reg <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
                if (!full_reg)
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            smp_reg <= sample;
        if (state_reg == F_READ)
        begin
            rec_reg.sum  <= sum_reg - (full_reg ? 32'(old_reg) : 32'd0) + 32'(smp_reg);
            rec_reg.span <= 32'((full_reg ? 32'(cnt_reg) : 32'(cnt_reg) + 32'd1)
                            * ADC_FULL_SCALE);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/tbtf_back.sv]
// Back part: rail check, log2 of four factors, beta equation divide, filter.
// Depends on tbtf_pkg.
`default_nettype none
module tbtf_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       rec_valid,
    output logic                      rec_ready,
    input  tbtf_pkg::avg_rec_t        rec,
    input  wire [12:0]                supply_mv,
    input  wire [19:0]                rfix,
    input  wire [19:0]                rnom,
    input  wire [12:0]                beta,
    input  wire [15:0]                t0,
    output logic                      res_valid,
    input  wire                       res_ready,
    output logic signed [15:0]        res_temp,
    output logic [1:0]                res_status
);
    typedef enum logic [11:0] {
        B_IDLE  = 12'b000000000001,
        B_CHK1  = 12'b000000000010,
        B_CHK2  = 12'b000000000100,
        B_NORM  = 12'b000000001000,
        B_SQ    = 12'b000000010000,
        B_LN    = 12'b000000100000,
        B_DEN1  = 12'b000001000000,
        B_DEN2  = 12'b000010000000,
        B_DIV   = 12'b000100000000,
        B_FILT  = 12'b001000000000,
        B_OUT   = 12'b010000000000,
        B_NUM   = 12'b100000000000
    } bstate_t;

    bstate_t state_reg;
    logic [31:0] sum_reg, span_reg;
    logic [45:0] p1_reg, p2_reg;
    logic [1:0]  fac_reg;
    logic [3:0]  it_reg;
    logic [32:0] m_reg;
    logic [4:0]  n_reg;
    logic [15:0] fr_reg;
    logic signed [28:0] l2_reg;
    logic signed [23:0] lq_reg;
    logic signed [47:0] den_reg;
    logic [51:0] num_reg, rem_reg, q_reg;
    logic [28:0] tbp_reg;
    logic [5:0]  dc_reg;
    logic signed [31:0] c_reg;
    logic signed [17:0] last_reg;
    logic signed [15:0] temp_reg;
    logic [1:0]  st_reg;
    logic [28:0] lmul_reg;
    logic        lneg_reg;

    assign rec_ready  = (state_reg == B_IDLE);
    assign res_valid  = (state_reg == B_OUT);
    assign res_temp   = temp_reg;
    assign res_status = st_reg;

    // Factor under log
    logic [31:0] fac_val;
    always_comb
    begin
        unique case (fac_reg)
            2'd0: fac_val = 32'(rfix);
            2'd1: fac_val = span_reg - sum_reg;
            2'd2: fac_val = sum_reg;
            default: fac_val = 32'(rnom);
        endcase
    end

    // Leading one position
    logic [4:0] lead;
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
            if (fac_val[i]) lead = 5'(i);
    end

    logic [65:0] sq;
    assign sq = 66'(m_reg) * 66'(m_reg);
    logic [34:0] msh;
    assign msh = 35'(sq >> 31);

    logic [20:0] lg;
    assign lg = {n_reg, fr_reg};

    // Partial remainder with the next numerator bit shifted in
    logic [51:0] rsh;
    assign rsh = {rem_reg[50:0], num_reg[51]};

    logic signed [31:0] diff;
    assign diff = c_reg - 32'(last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            last_reg  <= tbtf_pkg::LAST_RESET;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                    if (rec_valid)
                    begin
                        sum_reg   <= rec.sum;
                        span_reg  <= rec.span;
                        state_reg <= B_CHK1;
                    end
                B_CHK1:
                begin
                    p1_reg <= 46'(sum_reg) * 46'(supply_mv);
                    p2_reg <= 46'(span_reg) * 46'd100;
                    state_reg <= B_CHK2;
                end
                B_CHK2:
                begin
                    if (supply_mv <= 13'd100 || p1_reg <= p2_reg)
                    begin
                        temp_reg <= '0; st_reg <= tbtf_pkg::ST_VOLT; state_reg <= B_OUT;
                    end
                    else
                    begin
                        p2_reg <= 46'(span_reg) * 46'(supply_mv - 13'd100);
                        state_reg <= B_NUM;
                    end
                end
                B_NUM:
                begin
                    if (p1_reg >= p2_reg)
                    begin
                        temp_reg <= '0; st_reg <= tbtf_pkg::ST_VOLT; state_reg <= B_OUT;
                    end
                    else if (rfix == '0 || rnom == '0)
                    begin
                        temp_reg <= '0; st_reg <= tbtf_pkg::ST_RES; state_reg <= B_OUT;
                    end
                    else
                    begin
                        fac_reg <= 2'd0; l2_reg <= '0; state_reg <= B_NORM;
                    end
                end
                B_NORM:
                begin
                    n_reg  <= lead;
                    m_reg  <= 33'({fac_val, 31'd0} >> lead);
                    fr_reg <= '0;
                    it_reg <= '0;
                    state_reg <= B_SQ;
                end
                B_SQ:
                begin
                    if (msh[32])
                    begin
                        m_reg  <= 33'(msh >> 1);
                        fr_reg <= {fr_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        m_reg  <= 33'(msh);
                        fr_reg <= {fr_reg[14:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 4'd15) state_reg <= B_LN;
                end
                B_LN:
                begin
                    if (fac_reg[1])
                        l2_reg <= l2_reg - 29'(lg);
                    else
                        l2_reg <= l2_reg + 29'(lg);
                    fac_reg <= fac_reg + 1'b1;
                    state_reg <= (fac_reg == 2'd3) ? B_DEN1 : B_NORM;
                end
                B_DEN1:
                begin
                    lneg_reg <= l2_reg[28];
                    lmul_reg <= l2_reg[28] ? 29'(-l2_reg) : 29'(l2_reg);
                    state_reg <= B_DEN2;
                    it_reg <= '0;
                end
                B_DEN2:
                begin
                    // it_reg 0: scale by ln2, T0*B; 1: form den and num
                    if (it_reg == 4'd0)
                    begin
                        lq_reg <= lneg_reg
                            ? -24'((64'(lmul_reg) * 64'd2977044472 + 64'h80000000) >> 32)
                            :  24'((64'(lmul_reg) * 64'd2977044472 + 64'h80000000) >> 32);
                        tbp_reg <= 29'(t0) * 29'(beta);
                        it_reg <= 4'd1;
                    end
                    else
                    begin
                        den_reg <= $signed(48'(beta) * 48'd6553600)
                                   + 48'(lq_reg) * $signed({32'd0, t0});
                        num_reg <= 52'(tbp_reg) * 52'd6553600;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    if (den_reg == '0)
                    begin
                        c_reg <= 32'sd30000; state_reg <= B_FILT;
                    end
                    else if (den_reg < 0)
                    begin
                        c_reg <= -32'sd5000; state_reg <= B_FILT;
                    end
                    else
                    begin
                        num_reg <= num_reg + 52'(den_reg >>> 1);
                        rem_reg <= '0; q_reg <= '0; dc_reg <= '0;
                        state_reg <= B_FILT;
                        it_reg <= 4'd2;
                    end
                end
                B_FILT:
                begin
                    if (it_reg == 4'd2)
                    begin
                        // restoring division, one quotient bit a cycle
                        if (rsh >= 52'(den_reg))
                        begin
                            rem_reg <= rsh - 52'(den_reg);
                            q_reg   <= {q_reg[50:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rsh;
                            q_reg   <= {q_reg[50:0], 1'b0};
                        end
                        num_reg <= {num_reg[50:0], 1'b0};
                        dc_reg <= dc_reg + 1'b1;
                        if (dc_reg == 6'd51) it_reg <= 4'd3;
                    end
                    else if (it_reg == 4'd3)
                    begin
                        // kelvin to Celsius with saturation
                        if (q_reg > 52'd57315)
                            c_reg <= 32'sd30000;
                        else if (q_reg < 52'd22315)
                            c_reg <= -32'sd5000;
                        else
                            c_reg <= $signed(32'(q_reg[16:0])) - 32'sd27315;
                        it_reg <= 4'd0;
                    end
                    else
                    begin
                        if (diff < 32'sd100 && diff > -32'sd100)
                        begin
                            temp_reg <= 16'(last_reg); st_reg <= tbtf_pkg::ST_OK;
                        end
                        else
                        begin
                            last_reg <= 18'(c_reg);
                            if (c_reg < -32'sd100 || c_reg > 32'sd25000)
                            begin
                                temp_reg <= '0; st_reg <= tbtf_pkg::ST_RANGE;
                            end
                            else
                            begin
                                temp_reg <= 16'(c_reg); st_reg <= tbtf_pkg::ST_OK;
                            end
                        end
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                    if (res_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/tbtf_outq.sv]
// Two-entry result queue with empty/pop output.
// Depends on nothing beyond its ports.
`default_nettype none
module tbtf_outq (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr_valid,
    output logic               wr_ready,
    input  wire [17:0]         wr_data,
    output logic               empty,
    input  wire                pop,
    output logic [17:0]        rd_data
);
    logic [17:0] q_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign rd_data  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            q_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (pop && !empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/thermistor_beta_temperature_filter.sv]
// Channel   | signals                               | transfer when
// input     | push, full, adc_sample                | push && !full
// result    | empty, pop, temperature_centi, status | pop && !empty
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
// An item passes from input transfer to result through the front part, the back part
// (four log2 evaluations, a 52-bit restoring divider, then checks, scaling and
// filtering) and the result queue. Rail and resistor errors skip the log2 and divide
// steps. The front takes the next sample while the back is busy. Reset clears all
// control state; the window memory needs no clearing. A full result queue stalls the
// back, then the front.
// Depends on tbtf_pkg, tbtf_front, tbtf_back, tbtf_outq.
`default_nettype none
module thermistor_beta_temperature_filter #(
    parameter int WINDOW_DEPTH   = tbtf_pkg::WINDOW_DEPTH_DEF,
    parameter int ADC_FULL_SCALE = tbtf_pkg::ADC_FULL_SCALE_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    output logic              full,
    input  wire [9:0]         adc_sample,
    output logic              empty,
    input  wire               pop,
    output logic signed [15:0] temperature_centi,
    output logic [1:0]        status,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire [2:0]         cfg_index,
    input  wire [19:0]        cfg_data
);
    logic [12:0] supply_reg, beta_reg;
    logic [19:0] rfix_reg, rnom_reg;
    logic [15:0] t0_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= 13'd3300;
            rfix_reg   <= 20'd10000;
            rnom_reg   <= 20'd100000;
            beta_reg   <= 13'd3950;
            t0_reg     <= 16'd29815;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tbtf_pkg::REG_SUPPLY: supply_reg <= cfg_data[12:0];
                tbtf_pkg::REG_RFIX:   rfix_reg   <= cfg_data;
                tbtf_pkg::REG_RNOM:   rnom_reg   <= cfg_data;
                tbtf_pkg::REG_BETA:   beta_reg   <= cfg_data[12:0];
                tbtf_pkg::REG_T0:     t0_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic rec_valid, rec_ready, in_ready;
    tbtf_pkg::avg_rec_t rec;
    logic res_valid, res_ready;
    logic signed [15:0] res_temp;
    logic [1:0] res_status;
    logic [17:0] qd;

    assign full = !in_ready;

    tbtf_front #(.WINDOW_DEPTH(WINDOW_DEPTH), .ADC_FULL_SCALE(ADC_FULL_SCALE)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_ready(in_ready),
        .sample(adc_sample), .rec_valid(rec_valid), .rec_ready(rec_ready), .rec(rec)
    );

    tbtf_back u_back (
        .clk(clk), .rst_n(rst_n), .rec_valid(rec_valid), .rec_ready(rec_ready),
        .rec(rec), .supply_mv(supply_reg), .rfix(rfix_reg), .rnom(rnom_reg),
        .beta(beta_reg), .t0(t0_reg), .res_valid(res_valid), .res_ready(res_ready),
        .res_temp(res_temp), .res_status(res_status)
    );

    tbtf_outq u_q (
        .clk(clk), .rst_n(rst_n), .wr_valid(res_valid), .wr_ready(res_ready),
        .wr_data({res_temp, res_status}), .empty(empty), .pop(pop), .rd_data(qd)
    );

    assign temperature_centi = qd[17:2];
    assign status            = qd[1:0];
endmodule
`default_nettype wire

[hw/rtl/tbtf_checker.sv]
// Port-level checker for the filter, bound to the top level.
// Depends on tbtf_pkg and thermistor_beta_temperature_filter ports only.
`default_nettype none
module tbtf_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               push,
    input wire               full,
    input wire               empty,
    input wire               pop,
    input wire signed [15:0] temperature_centi,
    input wire [1:0]         status
);
    // Error results carry zero temperature
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != tbtf_pkg::ST_OK) |-> temperature_centi == 16'sd0)
        else $error("error result with nonzero temperature");

    // Reported temperature stays in the saturated range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (temperature_centi >= -16'sd5000 && temperature_centi <= 16'sd30000))
        else $error("temperature out of range");

    // Accepted input makes the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("input not held off after transfer");

    // Waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status)))
        else $error("result changed without pop");
endmodule

bind thermistor_beta_temperature_filter tbtf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .temperature_centi(temperature_centi), .status(status)
);
`default_nettype wire

[verif/thermistor_beta_temperature_filter_tb.sv]
// Self-checking testbench for the thermistor beta temperature filter.
// Holds a scoreboard class with an exact integer model of the block.
// Depends on tbtf_pkg and thermistor_beta_temperature_filter.
`timescale 1ns / 1ps

class temp_scoreboard;
    localparam int DEPTH = 64;
    localparam longint FULL_SCALE = 1023;
    localparam longint LN2_Q32 = 64'd2977044472;

    // Register copies
    longint supply, rfix, rnom, beta, t0;
    // Filter state
    int window_mem [DEPTH];
    longint run_sum;
    int slot_ptr;
    bit wrapped;
    longint last_temp;
    // Expected results
    logic signed [15:0] temp_q[$];
    logic [1:0] status_q[$];
    int mismatches;

    function void clear();
        supply = 3300;
        rfix = 10000;
        rnom = 100000;
        beta = 3950;
        t0 = 29815;
        run_sum = 0;
        slot_ptr = 0;
        wrapped = 0;
        last_temp = -99900;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [19:0] val);
        case (idx)
            tbtf_pkg::REG_SUPPLY: supply = val[12:0];
            tbtf_pkg::REG_RFIX:   rfix = val;
            tbtf_pkg::REG_RNOM:   rnom = val;
            tbtf_pkg::REG_BETA:   beta = val[12:0];
            tbtf_pkg::REG_T0:     t0 = val[15:0];
            default: ;
        endcase
    endfunction

    // Truncated base-2 log with 16 fraction bits, by repeated squaring
    function longint log2_q16(longint x);
        int n;
        longint t;
        logic [63:0] m;
        longint frac;
        n = 0;
        t = x;
        frac = 0;
        while (t > 1)
        begin
            t = t >> 1;
            n++;
        end
        m = (n <= 31) ? (x << (31 - n)) : (x >> (n - 31));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(n) << 16) | frac;
    endfunction

    function void note_sample(logic [9:0] sample);
        longint cnt, span, l2, l2mag, lmag, lq, den, num, c, diff;
        logic [63:0] prod;
        logic signed [15:0] tv;
        logic [1:0] sv;
        if (wrapped)
            run_sum -= window_mem[slot_ptr];
        window_mem[slot_ptr] = sample;
        run_sum += sample;
        slot_ptr++;
        if (slot_ptr >= DEPTH)
        begin
            slot_ptr = 0;
            wrapped = 1;
        end
        cnt = wrapped ? DEPTH : slot_ptr;
        span = cnt * FULL_SCALE;
        tv = 0;
        if (supply <= 100 || run_sum * supply <= 100 * span ||
            run_sum * supply >= (supply - 100) * span)
            sv = tbtf_pkg::ST_VOLT;
        else if (rfix == 0 || rnom == 0)
            sv = tbtf_pkg::ST_RES;
        else
        begin
            l2 = log2_q16(rfix) + log2_q16(span - run_sum) - log2_q16(run_sum)
                 - log2_q16(rnom);
            l2mag = l2 < 0 ? -l2 : l2;
            prod = 64'(l2mag) * 64'(LN2_Q32) + 64'h8000_0000;
            lmag = longint'(prod >> 32);
            lq = l2 < 0 ? -lmag : lmag;
            den = 100 * beta * 65536 + lq * t0;
            num = 100 * t0 * beta * 65536;
            if (den == 0)
                c = 30000;
            else if (den < 0)
                c = -5000;
            else
            begin
                c = (num + den / 2) / den - 27315;
                if (c > 30000) c = 30000;
                if (c < -5000) c = -5000;
            end
            diff = c - last_temp;
            if (diff < 0) diff = -diff;
            if (diff < 100)
            begin
                sv = tbtf_pkg::ST_OK;
                tv = last_temp[15:0];
            end
            else
            begin
                last_temp = c;
                if (c < -100 || c > 25000)
                    sv = tbtf_pkg::ST_RANGE;
                else
                begin
                    sv = tbtf_pkg::ST_OK;
                    tv = c[15:0];
                end
            end
        end
        temp_q.push_back(tv);
        status_q.push_back(sv);
    endfunction

    function void check_result(logic signed [15:0] tv, logic [1:0] sv);
        logic signed [15:0] et;
        logic [1:0] es;
        if (temp_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: temp=%0d status=%0d", tv, sv);
            return;
        end
        et = temp_q.pop_front();
        es = status_q.pop_front();
        if (tv !== et || sv !== es)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: temp exp %0d got %0d, status exp %0d got %0d",
                         et, tv, es, sv);
        end
    endfunction
endclass

module thermistor_beta_temperature_filter_tb;
    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic [9:0] adc_sample = '0;
    logic pop = 0;
    logic cfg_valid = 0;
    logic [2:0] cfg_index = '0;
    logic [19:0] cfg_data = '0;
    wire full, empty, cfg_ready;
    wire signed [15:0] temperature_centi;
    wire [1:0] status;

    temp_scoreboard sb;
    bit quiet_tail;      // no idling near the end
    int pop_idle_left = 0;
    int n_pending;

    thermistor_beta_temperature_filter u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .adc_sample(adc_sample),
        .empty(empty), .pop(pop), .temperature_centi(temperature_centi),
        .status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Result side: score each transfer, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(temperature_centi, status);
            if (pop_idle_left > 0)
            begin
                pop <= 1'b0;
                pop_idle_left <= pop_idle_left - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                pop_idle_left <= $urandom_range(0, 11);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic send_sample(logic [9:0] val);
        push <= 1'b1;
        adc_sample <= val;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_sample(val);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.temp_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_regs(int sup, int rf, int rn, int b, int tn);
        write_reg(tbtf_pkg::REG_SUPPLY, 20'(sup));
        write_reg(tbtf_pkg::REG_RFIX, 20'(rf));
        write_reg(tbtf_pkg::REG_RNOM, 20'(rn));
        write_reg(tbtf_pkg::REG_BETA, 20'(b));
        write_reg(tbtf_pkg::REG_T0, 20'(tn));
    endtask

    // Samples clustered around a divider midpoint, with occasional wild values
    function automatic logic [9:0] pick_sample(int center);
        int v;
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom_range(0, 1023));
        v = center + $signed($urandom_range(0, 80)) - 40;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return 10'(v);
    endfunction

    initial
    begin
        int center;
        sb = new();
        sb.clear();
        quiet_tail = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rails, midscale and steps under the reset settings
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd512);
        send_sample(10'd1);
        send_sample(10'd1022);
        for (int i = 0; i < 10; i++)
            send_sample(10'd900);
        for (int i = 0; i < 5; i++)
            send_sample(10'd100);
        drain();

        // Extreme settings: low supply, zero resistors, large values
        load_regs(1000, 100, 1000000, 1000, 25315);
        send_sample(10'h2AA);
        send_sample(10'h155);
        drain();
        write_reg(tbtf_pkg::REG_RFIX, 20'd0);
        send_sample(10'd700);
        drain();
        write_reg(tbtf_pkg::REG_RFIX, 20'hFFFFF);
        write_reg(tbtf_pkg::REG_RNOM, 20'd0);
        send_sample(10'd300);
        drain();
        write_reg(tbtf_pkg::REG_SUPPLY, 20'd50);   // supply at or under the rail margin
        send_sample(10'd512);
        drain();

        // Random phases with different settings, each ends idle
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_regs(3300, 10000, 100000, 3950, 29815);
                1: load_regs(5500, 1000000, 100, 6000, 37315);
                2: load_regs(1000, 100, 1000000, 1000, 25315);
                default: load_regs($urandom_range(1000, 5500), $urandom_range(100, 1000000),
                                   $urandom_range(100, 1000000), $urandom_range(1000, 6000),
                                   $urandom_range(25315, 37315));
            endcase
            center = $urandom_range(20, 1000);
            if (ph == 7)
                quiet_tail = 1;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 30) == 0)
                    center = $urandom_range(20, 1000);
                send_sample(pick_sample(center));
            end
            drain();
        end

        n_pending = sb.temp_q.size();
        if (sb.mismatches == 0 && n_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
